### sv/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

   // Field widths of the request and response words.
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Command codes; the remaining codes are treated as no operation.
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // Operation broadcast to every cell of the row.
   typedef struct packed {
      logic shift_right;   // push at the front: every word moves one cell back
      logic shift_left;    // pop from the front: every word moves one cell forward
      logic write_target;  // push at the back: the addressed cell loads the word
   } dq_ctrl_type;

endpackage

`default_nettype wire

### sv/dq_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dq_req_if;
   import dq_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;
   logic [INDEX_W-1:0] index;

   modport source (output valid, output command, output value, output index, input ready);
   modport sink   (input valid, input command, input value, input index, output ready);
endinterface

interface dq_rsp_if;
   import dq_pkg::*;

   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   data;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output data, output status, output count, input ready);
   modport sink   (input valid, input data, input status, input count, output ready);
endinterface

`default_nettype wire

### sv/dq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dq_cell #(
   parameter int IDX        = 0,
   parameter int DATA_WIDTH = 32,
   parameter int PW         = 4
) (
   input  wire                       clock,
   input  wire dq_pkg::dq_ctrl_type  ctrl,
   input  wire  [PW-1:0]             target,
   input  wire  [DATA_WIDTH-1:0]     push_word,
   input  wire  [DATA_WIDTH-1:0]     left_word,
   input  wire  [DATA_WIDTH-1:0]     right_word,
   input  wire  [DATA_WIDTH-1:0]     rd_in,
   output logic [DATA_WIDTH-1:0]     word_out,
   output logic [DATA_WIDTH-1:0]     rd_out
);
   import dq_pkg::*;

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;
   logic                  hit;

   assign hit = (target == PW'(IDX));

   always_comb begin
      word_in = word_ff;
      if (ctrl.shift_right) begin
         word_in = left_word;
      end else if (ctrl.shift_left) begin
         word_in = right_word;
      end else if (ctrl.write_target && hit) begin
         word_in = push_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // The read bus runs from the back of the row to the front; only the
   // addressed cell puts its word on it.
   assign rd_out   = rd_in | (hit ? word_ff : '0);
   assign word_out = word_ff;

endmodule

`default_nettype wire

### sv/double_ended_queue.sv
// Double-ended queue of data words with room for DEPTH words.
// Request channel req_port: command, value and index. Commands push a word at
// the back or the front, pop one from the back or the front, or read the word
// at a position counted from the front without removing it.
// Response channel rsp_port: exactly one word per request, carrying the word
// popped or read (zero otherwise), a status (ok, empty, full, out of range)
// and the number of stored words after the command.
// The words sit in a row of DEPTH cells, the front word in the first cell.
// Pushes and pops at the front shift the whole row by one cell at once.
// The response is registered at the edge that accepts the request.
// One command is taken per cycle while the response is consumed;
// the read path, an OR chain through all DEPTH cells, sets the clock rate.
// If the receiver stalls, the response is held and a new request is taken
// only in the cycle in which the held response leaves.
// Reset empties the queue and drops any pending response; the stored words
// themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
   parameter int DEPTH      = dq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
   input wire      clock,
   input wire      reset,
   dq_req_if.sink   req_port,
   dq_rsp_if.source rsp_port
);
   import dq_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int IW = (FW > INDEX_W) ? FW : INDEX_W;

   logic [FW-1:0]         fill_ff;
   logic [FW-1:0]         fill_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_W-1:0]     rsp_data_ff;
   logic [DATA_W-1:0]     rsp_data_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [STATUS_W-1:0]   rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [COUNT_W-1:0]    rsp_count_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  in_range;
   dq_ctrl_type           ctrl;
   logic [PW-1:0]         target;
   logic [DATA_WIDTH-1:0] push_word;
   logic [DATA_WIDTH-1:0] rd_word;

   logic [DATA_WIDTH-1:0] cell_word  [DEPTH];
   logic [DATA_WIDTH-1:0] left_word  [DEPTH];
   logic [DATA_WIDTH-1:0] right_word [DEPTH];
   logic [DATA_WIDTH-1:0] rd_chain   [DEPTH+1];

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   assign full      = (fill_ff == FW'(DEPTH));
   assign empty     = (fill_ff == '0);
   assign in_range  = (IW'(req_port.index) < IW'(fill_ff));
   assign push_word = DATA_WIDTH'(req_port.value);

   // Decode of the command into the row operation and the result.
   always_comb begin
      ctrl          = '0;
      target        = '0;
      fill_in       = fill_ff;
      rsp_status_in = ST_OK;
      rsp_data_in   = '0;
      case (req_port.command)
         CMD_PUSH_BACK: begin
            target = PW'(fill_ff);
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctrl.write_target = accept;
               fill_in           = fill_ff + FW'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               ctrl.shift_right = accept;
               fill_in          = fill_ff + FW'(1);
            end
         end
         CMD_POP_BACK: begin
            target = PW'(fill_ff - FW'(1));
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_data_in = DATA_W'(rd_word);
               fill_in     = fill_ff - FW'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               ctrl.shift_left = accept;
               rsp_data_in     = DATA_W'(rd_word);
               fill_in         = fill_ff - FW'(1);
            end
         end
         CMD_READ: begin
            target = PW'(req_port.index);
            if (!in_range) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_data_in = DATA_W'(rd_word);
            end
         end
         default: begin
         end
      endcase
      rsp_count_in = COUNT_W'(fill_in);
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_port.valid  = rsp_valid_ff;
   assign rsp_port.data   = rsp_data_ff;
   assign rsp_port.status = rsp_status_ff;
   assign rsp_port.count  = rsp_count_ff;

   assign rd_chain[DEPTH] = '0;
   assign rd_word         = rd_chain[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_word[i] = push_word;
      end else begin : g_inner_left
         assign left_word[i] = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_word[i] = '0;
      end else begin : g_inner_right
         assign right_word[i] = cell_word[i+1];
      end

      dq_cell #(
         .IDX        (i),
         .DATA_WIDTH (DATA_WIDTH),
         .PW         (PW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .target     (target),
         .push_word  (push_word),
         .left_word  (left_word[i]),
         .right_word (right_word[i]),
         .rd_in      (rd_chain[i+1]),
         .word_out   (cell_word[i]),
         .rd_out     (rd_chain[i])
      );
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("fill count beyond capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_count_ff == COUNT_W'(DEPTH)))
      else $error("full status with a queue that is not full");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |->
         (rsp_count_ff == '0 && rsp_data_ff == '0))
      else $error("empty status with stored words or a nonzero word");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req_port.command == CMD_PUSH_BACK ||
                           req_port.command == CMD_PUSH_FRONT))
      |=> (fill_ff == $past(fill_ff) + FW'(1)))
      else $error("accepted push did not grow the queue");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import dq_pkg::*;

   localparam int DEPTH = DEPTH_DEF;
   localparam int RANDOM_ITEMS = 1000;
   localparam int CALM_ITEMS = 150;
   localparam int STALL_AFTER = 300;
   localparam int STALL_CYCLES = 80;

   // Codes five to seven carry no operation.
   localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } dq_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               typed;
      dq_result_type      result;
   } dq_row_type;

   localparam dq_result_type UNTYPED = '0;

   // Opening rows: empty queue cases, a fill to the top with edge patterns,
   // refused pushes, reads at both ends and pops from both ends.
   localparam dq_row_type DIRECTED_ROWS [27] = '{
      '{CMD_POP_BACK,   32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
      '{CMD_POP_FRONT,  32'h0000_0000, 4'd0,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
      '{CMD_READ,       32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_RANGE, 5'd0}},
      '{CMD_NOP_FIRST,  32'hFFFF_FFFF, 4'd15, 1'b1, '{32'h0, ST_OK,    5'd0}},
      '{CMD_PUSH_BACK,  32'hFFFF_FFFF, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd1}},
      '{CMD_PUSH_FRONT, 32'h0000_0000, 4'd15, 1'b1, '{32'h0, ST_OK,    5'd2}},
      '{CMD_PUSH_BACK,  32'hAAAA_AAAA, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd3}},
      '{CMD_PUSH_FRONT, 32'h5555_5555, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd4}},
      '{CMD_PUSH_BACK,  32'h8000_0000, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd5}},
      '{CMD_PUSH_FRONT, 32'h0000_0001, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd6}},
      '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd7}},
      '{CMD_PUSH_FRONT, 32'hFFFF_FFFE, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd8}},
      '{CMD_PUSH_BACK,  32'h0F0F_0F0F, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd9}},
      '{CMD_PUSH_FRONT, 32'hF0F0_F0F0, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd10}},
      '{CMD_PUSH_BACK,  32'h1234_5678, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd11}},
      '{CMD_PUSH_FRONT, 32'h8765_4321, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd12}},
      '{CMD_PUSH_BACK,  32'hDEAD_BEEF, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd13}},
      '{CMD_PUSH_FRONT, 32'hCAFE_F00D, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd14}},
      '{CMD_PUSH_BACK,  32'h00FF_00FF, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd15}},
      '{CMD_PUSH_FRONT, 32'hFF00_FF00, 4'd0,  1'b1, '{32'h0, ST_OK,    5'd16}},
      '{CMD_PUSH_BACK,  32'h1111_1111, 4'd0,  1'b1, '{32'h0, ST_FULL,  5'd16}},
      '{CMD_PUSH_FRONT, 32'h2222_2222, 4'd0,  1'b1, '{32'h0, ST_FULL,  5'd16}},
      '{CMD_READ,       32'h0000_0000, 4'd15, 1'b0, UNTYPED},
      '{CMD_READ,       32'hFFFF_FFFF, 4'd0,  1'b0, UNTYPED},
      '{CMD_POP_FRONT,  32'h0000_0000, 4'd0,  1'b0, UNTYPED},
      '{CMD_POP_BACK,   32'h0000_0000, 4'd0,  1'b0, UNTYPED},
      '{CMD_READ,       32'h0000_0000, 4'd14, 1'b1, '{32'h0, ST_RANGE, 5'd14}}
   };

   logic clock;
   logic reset;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   // Model of the queue, kept as a ring buffer.
   logic [DATA_W-1:0]  ring_words [DEPTH];
   logic [INDEX_W-1:0] ring_head;
   logic [COUNT_W-1:0] ring_fill;

   dq_result_type pending_words [$];
   int            mismatches;
   int            accepted_requests;
   bit            calm;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [INDEX_W-1:0] ring_slot(input int offset);
      return INDEX_W'((int'(ring_head) + offset) % DEPTH);
   endfunction

   function automatic dq_result_type deque_apply(input logic [CMD_W-1:0] command,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [INDEX_W-1:0] index);
      dq_result_type outcome;
      outcome = '0;
      outcome.status = ST_OK;
      case (command)
         CMD_PUSH_BACK: begin
            if (ring_fill >= DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               ring_words[ring_slot(int'(ring_fill))] = value;
               ring_fill = ring_fill + 1'b1;
            end
         end
         CMD_PUSH_FRONT: begin
            if (ring_fill >= DEPTH) begin
               outcome.status = ST_FULL;
            end else begin
               ring_head = ring_slot(DEPTH - 1);
               ring_words[ring_head] = value;
               ring_fill = ring_fill + 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (ring_fill == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.data = ring_words[ring_slot(int'(ring_fill) - 1)];
               ring_fill = ring_fill - 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (ring_fill == 0) begin
               outcome.status = ST_EMPTY;
            end else begin
               outcome.data = ring_words[ring_head];
               ring_head = ring_slot(1);
               ring_fill = ring_fill - 1'b1;
            end
         end
         CMD_READ: begin
            if (COUNT_W'(index) >= ring_fill) begin
               outcome.status = ST_RANGE;
            end else begin
               outcome.data = ring_words[ring_slot(int'(index))];
            end
         end
         default: begin
         end
      endcase
      outcome.count = ring_fill;
      return outcome;
   endfunction

   task automatic report(input string message);
      mismatches++;
      $display("%0t ns: %s", $time, message);
   endtask

   // Offers one word, waits for it to be taken and records what it should
   // bring back. A gap, when drawn, comes before the word is offered.
   task automatic send_request(input logic [CMD_W-1:0] command,
                               input logic [VALUE_W-1:0] value,
                               input logic [INDEX_W-1:0] index,
                               input bit typed,
                               input dq_result_type typed_result);
      dq_result_type predicted;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= command;
      req_ch.value   <= value;
      req_ch.index   <= index;
      do @(posedge clock); while (!req_ch.ready);
      predicted = deque_apply(command, value, index);
      pending_words.push_back(typed ? typed_result : predicted);
      accepted_requests++;
   endtask

   function automatic logic [CMD_W-1:0] pick_command(input bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll >= 95) return CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST));
      if (roll >= 80) return CMD_READ;
      if (filling) begin
         if (roll < 35) return CMD_PUSH_BACK;
         if (roll < 60) return CMD_PUSH_FRONT;
         if (roll < 70) return CMD_POP_BACK;
         return CMD_POP_FRONT;
      end
      if (roll < 10) return CMD_PUSH_BACK;
      if (roll < 20) return CMD_PUSH_FRONT;
      if (roll < 50) return CMD_POP_BACK;
      return CMD_POP_FRONT;
   endfunction

   initial begin : drive_requests
      int run_left;
      bit filling;
      logic [VALUE_W-1:0] value;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_PUSH_BACK;
      req_ch.value = '0;
      req_ch.index = '0;
      ring_head = '0;
      ring_fill = '0;
      foreach (ring_words[i]) ring_words[i] = '0;
      mismatches = 0;
      accepted_requests = 0;
      calm = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_request(DIRECTED_ROWS[i].command, DIRECTED_ROWS[i].value,
                      DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].result);
      end

      // Runs that lean towards pushing alternate with runs that lean
      // towards popping, so the queue swings between empty and full.
      run_left = 0;
      filling = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (run_left == 0) begin
            filling = ~filling;
            run_left = $urandom_range(20, 60);
         end
         run_left--;
         if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         case ($urandom_range(0, 7))
            0: value = '1;
            1: value = '0;
            default: value = $urandom;
         endcase
         send_request(pick_command(filling), value, INDEX_W'($urandom_range(0, 15)),
                      1'b0, UNTYPED);
      end
      req_ch.valid <= 1'b0;

      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Receiver: random stalls, one long hold-off once the run is under way
   // so that the held response blocks the input, and no stalls at the end.
   initial begin : drive_ready
      bit held_off;
      held_off = 1'b0;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && !held_off && accepted_requests >= STALL_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_responses
      dq_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_words.size() == 0) begin
            report($sformatf("response word with none expected: data %h status %0d count %0d",
                             rsp_ch.data, rsp_ch.status, rsp_ch.count));
         end else begin
            want = pending_words.pop_front();
            if (rsp_ch.data !== want.data)
               report($sformatf("data %h, expected %h", rsp_ch.data, want.data));
            if (rsp_ch.status !== want.status)
               report($sformatf("status %0d, expected %0d", rsp_ch.status, want.status));
            if (rsp_ch.count !== want.count)
               report($sformatf("count %0d, expected %0d", rsp_ch.count, want.count));
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

### double_ended_queue.f
sv/dq_pkg.sv
sv/dq_if.sv
sv/dq_cell.sv
sv/double_ended_queue.sv
tb/testbench.sv
